@@ rtl/rfpp_pkg.sv @@
// Package for the radar frame presence parser: word types, frame constants and header lookup.
package rfpp_pkg;

    // Frame layout constants.
    localparam int unsigned SLOT_COUNT_DEFAULT = 3;
    localparam int unsigned SLOT_BYTES         = 8;
    localparam int unsigned SLOT_SHIFT         = $clog2(SLOT_BYTES);
    localparam int unsigned BYTE_POS_W         = 5;
    localparam int unsigned COUNT_W            = 32;

    localparam logic [BYTE_POS_W-1:0] BODY_START = 5'd4;
    localparam logic [BYTE_POS_W-1:0] TAIL_POS   = 5'd28;
    localparam logic [BYTE_POS_W-1:0] FRAME_LAST = 5'd29;

    // Header and tail byte values.
    localparam logic [7:0] HDR_BYTE0  = 8'hAA;
    localparam logic [7:0] HDR_BYTE1  = 8'hFF;
    localparam logic [7:0] HDR_BYTE2  = 8'h03;
    localparam logic [7:0] HDR_BYTE3  = 8'h00;
    localparam logic [7:0] TAIL_BYTE0 = 8'h55;
    localparam logic [7:0] TAIL_BYTE1 = 8'hCC;

    // One received byte with its counter clear request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       clear_counts;
    } in_word_t;

    // One frame result.
    typedef struct packed {
        logic               frame_ok;
        logic [1:0]         active_count;
        logic [COUNT_W-1:0] good_frames;
        logic [COUNT_W-1:0] bad_frames;
    } out_word_t;

    // Expected header byte at a given match position.
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0: b = HDR_BYTE0;
            2'd1: b = HDR_BYTE1;
            2'd2: b = HDR_BYTE2;
            2'd3: b = HDR_BYTE3;
            default: b = HDR_BYTE0;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/radar_frame_presence_parser_core.sv @@
// Radar frame presence parser: header sync, slot tracking, tail check and frame counters.
//
// Usage: bytes of the radar serial stream enter on the rx channel (rx_valid, rx_ready,
// rx_data), one word per byte, each with a clear_counts flag that zeroes the good and
// bad frame counters before that byte is handled. The parser hunts for the header
// AA FF 03 00, then takes 26 body bytes: three 8-byte target slots and the tail 55 CC.
// Only the 30th byte of a frame produces a word on the res channel (res_valid,
// res_ready, res_data) carrying the tail verdict, the active-target count of the last
// good frame and both wrapping counters.
// Throughput is one byte per cycle while no closing byte waits on a pending result. A
// result word is registered in the cycle after its closing byte; others produce nothing.
// All per-byte work is a small compare and increment on the parser state registers.
// When the receiver stalls with a result pending, rx_ready stays high until another
// result would be needed; the next frame end then waits for res_ready.
// Reset clears the sync state, the stored target count, both counters and res_valid.
module radar_frame_presence_parser_core #(
    parameter int unsigned SLOT_COUNT = rfpp_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  rfpp_pkg::in_word_t  rx_data,
    output logic               res_valid,
    input  logic               res_ready,
    output rfpp_pkg::out_word_t res_data
);

    localparam int unsigned PW = rfpp_pkg::BYTE_POS_W;
    localparam int unsigned CW = rfpp_pkg::COUNT_W;

    // Parser state.
    logic [1:0]            header_pos_reg, header_pos_next;
    logic                  in_frame_reg, in_frame_next;
    logic [PW-1:0]         byte_pos_reg, byte_pos_next;
    logic [SLOT_COUNT-1:0] slot_nz_reg, slot_nz_next;
    logic [7:0]            tail_first_reg, tail_first_next;
    logic [1:0]            target_count_reg, target_count_next;
    logic [CW-1:0]         good_count_reg, good_count_next;
    logic [CW-1:0]         bad_count_reg, bad_count_next;

    // Output register.
    logic                  res_valid_reg, res_valid_next;
    rfpp_pkg::out_word_t   res_data_reg, res_data_next;

    logic                  accept;
    logic                  frame_end;
    logic [PW-1:0]         body_off;
    logic [1:0]            slot_idx;
    logic [1:0]            nz_count;
    logic                  tail_ok;
    logic [CW-1:0]         good_base;
    logic [CW-1:0]         bad_base;

    // Only a closing byte needs the output register, so only it waits for a
    // pending word to drain; all other bytes enter freely.
    assign frame_end = in_frame_reg && (byte_pos_reg == rfpp_pkg::FRAME_LAST);
    assign rx_ready  = !frame_end || !res_valid_reg || res_ready;
    assign accept    = rx_valid && rx_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Slot index of the current body byte.
    assign body_off = byte_pos_reg - rfpp_pkg::BODY_START;
    assign slot_idx = body_off[rfpp_pkg::SLOT_SHIFT +: 2];

    // Count of slots that held a nonzero byte.
    always_comb
    begin
        nz_count = 2'd0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            nz_count = nz_count + {1'b0, slot_nz_reg[i]};
        end
    end

    assign tail_ok   = (tail_first_reg == rfpp_pkg::TAIL_BYTE0)
                    && (rx_data.data_byte == rfpp_pkg::TAIL_BYTE1);
    assign good_base = rx_data.clear_counts ? '0 : good_count_reg;
    assign bad_base  = rx_data.clear_counts ? '0 : bad_count_reg;

    // Next state and result for the accepted byte.
    always_comb
    begin
        header_pos_next   = header_pos_reg;
        in_frame_next     = in_frame_reg;
        byte_pos_next     = byte_pos_reg;
        slot_nz_next      = slot_nz_reg;
        tail_first_next   = tail_first_reg;
        target_count_next = target_count_reg;
        good_count_next   = good_count_reg;
        bad_count_next    = bad_count_reg;
        res_valid_next    = res_valid_reg && !res_ready;
        res_data_next     = res_data_reg;

        if (accept)
        begin
            good_count_next = good_base;
            bad_count_next  = bad_base;

            if (!in_frame_reg)
            begin
                // Header hunt; a mismatching AA still counts as a first header byte.
                if (rx_data.data_byte == rfpp_pkg::hdr_byte(header_pos_reg))
                begin
                    if (header_pos_reg == 2'd3)
                    begin
                        in_frame_next   = 1'b1;
                        byte_pos_next   = rfpp_pkg::BODY_START;
                        header_pos_next = 2'd0;
                        slot_nz_next    = '0;
                        tail_first_next = 8'h00;
                    end
                    else
                    begin
                        header_pos_next = header_pos_reg + 2'd1;
                    end
                end
                else
                begin
                    header_pos_next = (rx_data.data_byte == rfpp_pkg::HDR_BYTE0) ? 2'd1 : 2'd0;
                end
            end
            else
            begin
                // Body bytes: mark nonzero slots and keep the first tail byte.
                if (byte_pos_reg < rfpp_pkg::TAIL_POS)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (slot_idx == 2'(i) && rx_data.data_byte != 8'h00)
                        begin
                            slot_nz_next[i] = 1'b1;
                        end
                    end
                end
                else if (byte_pos_reg == rfpp_pkg::TAIL_POS)
                begin
                    tail_first_next = rx_data.data_byte;
                end

                if (byte_pos_reg == rfpp_pkg::FRAME_LAST)
                begin
                    // Frame end: judge the tail, update counters and emit a word.
                    in_frame_next = 1'b0;
                    byte_pos_next = '0;
                    if (tail_ok)
                    begin
                        target_count_next = nz_count;
                        good_count_next   = good_base + CW'(1);
                    end
                    else
                    begin
                        bad_count_next = bad_base + CW'(1);
                    end
                    res_valid_next             = 1'b1;
                    res_data_next.frame_ok     = tail_ok;
                    res_data_next.active_count = tail_ok ? nz_count : target_count_reg;
                    res_data_next.good_frames  = good_count_next;
                    res_data_next.bad_frames   = bad_count_next;
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + PW'(1);
                end
            end
        end
    end

    // Control and parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg   <= 2'd0;
            in_frame_reg     <= 1'b0;
            byte_pos_reg     <= '0;
            slot_nz_reg      <= '0;
            tail_first_reg   <= 8'h00;
            target_count_reg <= 2'd0;
            good_count_reg   <= '0;
            bad_count_reg    <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            header_pos_reg   <= header_pos_next;
            in_frame_reg     <= in_frame_next;
            byte_pos_reg     <= byte_pos_next;
            slot_nz_reg      <= slot_nz_next;
            tail_first_reg   <= tail_first_next;
            target_count_reg <= target_count_next;
            good_count_reg   <= good_count_next;
            bad_count_reg    <= bad_count_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

endmodule
